@@ hw/rtl/lzwd_pkg.sv @@
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared types and constants for the variable-width LZW decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_WALK   = 5'b00100,
        S_POP    = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    localparam logic [1:0] STATUS_DATA    = 2'd0;
    localparam logic [1:0] STATUS_END     = 2'd1;
    localparam logic [1:0] STATUS_OVERRUN = 2'd2;

    localparam logic [3:0] MIN_CODE_BITS = 4'd9;

    typedef struct packed {
        logic accept;
        logic decode;
        logic walk;
        logic pop;
        logic taken;
    } t_cmd;

    typedef struct packed {
        logic stopped;
        logic code_ready;
        logic is_literal;
        logic is_end;
        logic is_reset;
        logic chain_end;
        logic overrun;
        logic sp_zero;
        logic pop_stop;
        logic last;
    } t_sts;

endpackage

@@ hw/rtl/lzwd_ram.sv @@
// ----------------------------------------------------------------------------
// lzwd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/lzwd_ctrl.sv @@
// ----------------------------------------------------------------------------
// lzwd_ctrl
// Sequencer: accept, decode, chain walk, stack pop and result hand-off.
// ----------------------------------------------------------------------------
module lzwd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  lzwd_pkg::t_sts i_sts,
    output lzwd_pkg::t_cmd o_cmd
);

    lzwd_pkg::t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lzwd_pkg::S_IDLE: begin
                if (i_valid && !i_sts.stopped && i_sts.code_ready) begin
                    n_state = lzwd_pkg::S_DECODE;
                end
            end
            lzwd_pkg::S_DECODE: begin
                if (i_sts.is_literal || i_sts.is_end) begin
                    n_state = lzwd_pkg::S_OUT;
                end else if (i_sts.is_reset) begin
                    n_state = lzwd_pkg::S_IDLE;
                end else begin
                    n_state = lzwd_pkg::S_WALK;
                end
            end
            lzwd_pkg::S_WALK: begin
                if (i_sts.chain_end) begin
                    n_state = i_sts.sp_zero ? lzwd_pkg::S_OUT : lzwd_pkg::S_POP;
                end else if (i_sts.overrun) begin
                    n_state = lzwd_pkg::S_OUT;
                end
            end
            lzwd_pkg::S_POP: begin
                if (i_sts.pop_stop) begin
                    n_state = lzwd_pkg::S_OUT;
                end
            end
            lzwd_pkg::S_OUT: begin
                if (!i_stall) begin
                    n_state = i_sts.last ? lzwd_pkg::S_IDLE : lzwd_pkg::S_POP;
                end
            end
            default: n_state = lzwd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lzwd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall      = (r_state != lzwd_pkg::S_IDLE);
    assign o_valid      = (r_state == lzwd_pkg::S_OUT);
    assign o_cmd.accept = (r_state == lzwd_pkg::S_IDLE) && i_valid;
    assign o_cmd.decode = (r_state == lzwd_pkg::S_DECODE);
    assign o_cmd.walk   = (r_state == lzwd_pkg::S_WALK);
    assign o_cmd.pop    = (r_state == lzwd_pkg::S_POP);
    assign o_cmd.taken  = (r_state == lzwd_pkg::S_OUT) && !i_stall;

endmodule

@@ hw/rtl/lzwd_dpath.sv @@
// ----------------------------------------------------------------------------
// lzwd_dpath
// Bit buffer, code extraction, dictionary, output stack and chunk assembly.
// ----------------------------------------------------------------------------
module lzwd_dpath #(
    parameter int MAX_CODE_BITS = 14,
    parameter int DICT_ENTRIES  = 16384,
    parameter int STACK_DEPTH   = 512
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [3:0]     i_cfg_data,
    input  logic [7:0]     i_compressed_byte,
    input  lzwd_pkg::t_cmd i_cmd,
    output lzwd_pkg::t_sts o_sts,
    output logic [63:0]    o_out_bytes,
    output logic [3:0]     o_byte_count,
    output logic           o_last_of_run,
    output logic [1:0]     o_status
);

    localparam int MB    = MAX_CODE_BITS;
    localparam int WBITS = $clog2(MAX_CODE_BITS + 1);
    localparam int DAW   = $clog2(DICT_ENTRIES);
    localparam int SAW   = $clog2(STACK_DEPTH);
    localparam int WW    = ((MB > DAW) ? MB : DAW) + 1;
    localparam int DW    = MB + 8;

    logic [23:0]      r_buf, n_buf;
    logic [4:0]       r_avail, n_avail;
    logic [WBITS-1:0] r_width, n_width;
    logic [WW-1:0]    r_nfc, n_nfc;
    logic [MB-1:0]    r_prev, n_prev;
    logic [7:0]       r_first, n_first;
    logic             r_lit, n_lit;
    logic             r_stop, n_stop;
    logic [MB-1:0]    r_b, n_b;
    logic [SAW-1:0]   r_sp, n_sp;
    logic [63:0]      r_acc, n_acc;
    logic [3:0]       r_cnt, n_cnt;
    logic             r_last, n_last;
    logic [1:0]       r_status, n_status;

    logic [MB-1:0]    mask, code;
    logic [23:0]      shifted;
    logic [5:0]       avail_sum;
    logic [WW-1:0]    code_ext, b_ext, nb_ext, nfc_inc;
    logic             b_past;
    logic [DW-1:0]    d_rdata;
    logic [MB-1:0]    d_prefix;
    logic [7:0]       d_suffix;
    logic             d_we;
    logic [7:0]       s_rdata, s_wdata;
    logic             s_we;
    logic [SAW-1:0]   s_raddr;
    logic [WBITS-1:0] cfg_width;

    assign mask      = ~({MB{1'b1}} << r_width);
    assign shifted   = r_buf >> r_avail;
    assign code      = shifted[MB-1:0] & mask;
    assign avail_sum = 6'(r_avail) + 6'd8;
    assign code_ext  = WW'(code);
    assign b_ext     = WW'(r_b);
    assign nb_ext    = WW'(n_b);
    assign b_past    = (b_ext >= WW'(DICT_ENTRIES));
    assign d_prefix  = b_past ? '0 : d_rdata[DW-1:8];
    assign d_suffix  = b_past ? 8'd0 : d_rdata[7:0];
    assign nfc_inc   = r_nfc + WW'(1);

    always_comb begin
        if (i_cfg_data < lzwd_pkg::MIN_CODE_BITS) begin
            cfg_width = WBITS'(lzwd_pkg::MIN_CODE_BITS);
        end else if (WBITS'(i_cfg_data) > WBITS'(MAX_CODE_BITS)) begin
            cfg_width = WBITS'(MAX_CODE_BITS);
        end else begin
            cfg_width = WBITS'(i_cfg_data);
        end
    end

    assign o_sts.stopped    = r_stop;
    assign o_sts.code_ready = (avail_sum >= 6'(r_width));
    assign o_sts.is_literal = r_lit;
    assign o_sts.is_end     = (code == mask);
    assign o_sts.is_reset   = (code == (mask - MB'(1)));
    assign o_sts.chain_end  = (b_ext < WW'(256));
    assign o_sts.overrun    = (r_sp >= SAW'(STACK_DEPTH - 1));
    assign o_sts.sp_zero    = (r_sp == '0);
    assign o_sts.pop_stop   = (r_sp == SAW'(1)) || (r_cnt == 4'd7);
    assign o_sts.last       = r_last;

    always_comb begin
        n_buf    = r_buf;
        n_avail  = r_avail;
        n_width  = r_width;
        n_nfc    = r_nfc;
        n_prev   = r_prev;
        n_first  = r_first;
        n_lit    = r_lit;
        n_stop   = r_stop;
        n_b      = r_b;
        n_sp     = r_sp;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_last   = r_last;
        n_status = r_status;
        d_we     = 1'b0;
        s_we     = 1'b0;
        s_wdata  = d_suffix;

        if (i_cfg_we) begin
            n_width = cfg_width;
        end

        if (i_cmd.accept && !r_stop) begin
            n_buf = {r_buf[15:0], i_compressed_byte};
            if (o_sts.code_ready) begin
                n_avail = 5'(avail_sum - 6'(r_width));
            end else begin
                n_avail = avail_sum[4:0];
            end
        end

        if (i_cmd.decode) begin
            if (r_lit) begin
                n_lit    = 1'b0;
                n_prev   = code;
                n_first  = code[7:0];
                n_acc    = 64'(code[7:0]);
                n_cnt    = 4'd1;
                n_last   = 1'b1;
                n_status = lzwd_pkg::STATUS_DATA;
            end else if (o_sts.is_end) begin
                n_stop   = 1'b1;
                n_acc    = '0;
                n_cnt    = 4'd0;
                n_last   = 1'b1;
                n_status = lzwd_pkg::STATUS_END;
            end else if (o_sts.is_reset) begin
                n_nfc = WW'(256);
                n_lit = 1'b1;
            end else if (code_ext >= r_nfc) begin
                s_we    = 1'b1;
                s_wdata = r_first;
                n_sp    = SAW'(1);
                n_b     = r_prev;
            end else begin
                n_sp = '0;
                n_b  = code;
            end
        end

        if (i_cmd.walk) begin
            if (o_sts.chain_end) begin
                n_first  = r_b[7:0];
                n_acc    = 64'(r_b[7:0]);
                n_cnt    = 4'd1;
                n_last   = o_sts.sp_zero;
                n_status = lzwd_pkg::STATUS_DATA;
                if (r_nfc < WW'(DICT_ENTRIES)) begin
                    d_we  = 1'b1;
                    n_nfc = nfc_inc;
                end
                if ((n_nfc > (WW'(mask) - WW'(3))) && (r_width < WBITS'(MAX_CODE_BITS))) begin
                    n_width = r_width + WBITS'(1);
                end
                n_prev = code;
            end else if (o_sts.overrun) begin
                n_stop   = 1'b1;
                n_acc    = '0;
                n_cnt    = 4'd0;
                n_last   = 1'b1;
                n_status = lzwd_pkg::STATUS_OVERRUN;
            end else begin
                s_we = 1'b1;
                n_sp = r_sp + SAW'(1);
                n_b  = d_prefix;
            end
        end

        if (i_cmd.pop) begin
            n_acc[8*r_cnt[2:0] +: 8] = s_rdata;
            n_cnt  = r_cnt + 4'd1;
            n_sp   = r_sp - SAW'(1);
            n_last = (r_sp == SAW'(1));
        end

        if (i_cmd.taken && !r_last) begin
            n_acc = '0;
            n_cnt = 4'd0;
        end
    end

    assign s_raddr = n_sp - SAW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf   <= '0;
            r_avail <= '0;
            r_width <= WBITS'(lzwd_pkg::MIN_CODE_BITS);
            r_nfc   <= WW'(256);
            r_prev  <= '0;
            r_first <= '0;
            r_lit   <= 1'b1;
            r_stop  <= 1'b0;
            r_sp    <= '0;
            r_cnt   <= '0;
            r_last  <= 1'b0;
        end else begin
            r_buf   <= n_buf;
            r_avail <= n_avail;
            r_width <= n_width;
            r_nfc   <= n_nfc;
            r_prev  <= n_prev;
            r_first <= n_first;
            r_lit   <= n_lit;
            r_stop  <= n_stop;
            r_sp    <= n_sp;
            r_cnt   <= n_cnt;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b      <= n_b;
        r_acc    <= n_acc;
        r_status <= n_status;
    end

    lzwd_ram #(
        .WIDTH (DW),
        .DEPTH (DICT_ENTRIES)
    ) u_dict (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (r_nfc[DAW-1:0]),
        .i_wdata ({r_prev, r_b[7:0]}),
        .i_raddr (nb_ext[DAW-1:0]),
        .o_rdata (d_rdata)
    );

    lzwd_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (r_sp),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    assign o_out_bytes   = r_acc;
    assign o_byte_count  = r_cnt;
    assign o_last_of_run = r_last;
    assign o_status      = r_status;

endmodule

@@ hw/rtl/lzw_variable_width_decoder.sv @@
// ----------------------------------------------------------------------------
// lzw_variable_width_decoder
// Variable-width LZW decoder, one packed byte per transaction in, chunks of
// up to eight decoded bytes out.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | i_valid / o_stall  | i_compressed_byte
//  out     | o_valid / i_stall  | o_out_bytes, o_byte_count, o_last_of_run,
//          |                    | o_status
//  cfg     | i_cfg_we           | i_cfg_data
//
// A byte that completes no code is only shifted into the bit buffer; one that
// completes a code is decoded, then walks its dictionary chain step by step (one
// dictionary read port), pops the stacked bytes and hands off each chunk.
// Synchronous active-low reset; the dictionary and stack need no clearing.
// o_stall is high from the cycle after an accepted code until its last chunk
// is taken (a reset code: until it is decoded); a stalled result holds all later work.
// ----------------------------------------------------------------------------
module lzw_variable_width_decoder #(
    parameter int MAX_CODE_BITS = 14,
    parameter int DICT_ENTRIES  = 16384,
    parameter int STACK_DEPTH   = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_compressed_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_out_bytes,
    output logic [3:0]  o_byte_count,
    output logic        o_last_of_run,
    output logic [1:0]  o_status
);

    lzwd_pkg::t_cmd cmd;
    lzwd_pkg::t_sts sts;

    lzwd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    lzwd_dpath #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .DICT_ENTRIES  (DICT_ENTRIES),
        .STACK_DEPTH   (STACK_DEPTH)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_compressed_byte (i_compressed_byte),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_out_bytes       (o_out_bytes),
        .o_byte_count      (o_byte_count),
        .o_last_of_run     (o_last_of_run),
        .o_status          (o_status)
    );

endmodule

@@ test/lzw_variable_width_decoder_checker.sv @@
// ----------------------------------------------------------------------------
// lzw_variable_width_decoder_checker
// Watches the input, output and register ports of the decoder, expands every
// accepted byte into the chunks it must produce and compares each accepted
// output transaction field by field against the oldest pending chunk.
// ----------------------------------------------------------------------------
module lzw_variable_width_decoder_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_compressed_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [63:0] i_out_bytes,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last_of_run,
    input  logic [1:0]  i_status,
    output int          o_fails,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DICT  = 16384;
    localparam int STACK = 512;
    localparam int MAXB  = 14;

    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  cnt;
        logic        last;
        logic [1:0]  st;
    } t_chunk;

    t_chunk      chunk_q[$];
    logic [23:0] bitbuf;
    int unsigned avail, width, nfree, prevc, fch;
    bit          lit_next, halted;
    logic [13:0] pfx[DICT];
    logic [7:0]  sfx[DICT];
    logic [7:0]  stk[STACK];

    function automatic int unsigned clamp_bits(input logic [3:0] v);
        if (v < lzwd_pkg::MIN_CODE_BITS) return lzwd_pkg::MIN_CODE_BITS;
        if (v > MAXB) return MAXB;
        return v;
    endfunction

    function automatic void add_chunk(input logic [63:0] b, input int unsigned c,
                                      input bit l, input logic [1:0] s);
        t_chunk r;
        r.bytes = b;
        r.cnt   = 4'(c);
        r.last  = l;
        r.st    = s;
        chunk_q.push_back(r);
    endfunction

    task automatic decode_byte(input logic [7:0] b);
        int unsigned msk, code, ch, n, cnt, i;
        logic [63:0] acc;
        if (halted) return;
        bitbuf = {bitbuf[15:0], b};
        avail += 8;
        if (avail < width) return;
        avail -= width;
        msk  = (1 << width) - 1;
        code = int'(bitbuf >> avail) & msk;
        if (lit_next) begin
            lit_next = 0;
            prevc = code;
            fch = code & 8'hFF;
            add_chunk(64'(code & 8'hFF), 1, 1, lzwd_pkg::STATUS_DATA);
            return;
        end
        if (code == msk) begin
            halted = 1;
            add_chunk(64'd0, 0, 1, lzwd_pkg::STATUS_END);
            return;
        end
        if (code == msk - 1) begin
            nfree = 256;
            lit_next = 1;
            return;
        end
        n = 0;
        if (code >= nfree) begin
            stk[n] = 8'(fch);
            n++;
            ch = prevc;
        end else begin
            ch = code;
        end
        while (ch > 8'hFF) begin
            if (n >= STACK - 1) begin
                halted = 1;
                add_chunk(64'd0, 0, 1, lzwd_pkg::STATUS_OVERRUN);
                return;
            end
            if (ch < DICT) begin
                stk[n] = sfx[ch];
                ch = pfx[ch];
            end else begin
                stk[n] = 8'd0;
                ch = 0;
            end
            n++;
        end
        stk[n] = 8'(ch);
        n++;
        fch = ch;
        acc = '0;
        cnt = 0;
        for (i = n; i > 0; i--) begin
            acc |= 64'(stk[i-1]) << (8 * cnt);
            cnt++;
            if (cnt == 8 || i == 1) begin
                add_chunk(acc, cnt, i == 1, lzwd_pkg::STATUS_DATA);
                acc = '0;
                cnt = 0;
            end
        end
        if (nfree < DICT) begin
            pfx[nfree] = 14'(prevc);
            sfx[nfree] = 8'(fch);
            nfree++;
        end
        if (nfree > msk - 3 && width < MAXB) width++;
        prevc = code;
    endtask

    always @(posedge i_clk) begin
        t_chunk e;
        if (!i_rst_n) begin
            bitbuf = '0;
            avail = 0;
            width = lzwd_pkg::MIN_CODE_BITS;
            nfree = 256;
            prevc = 0;
            fch = 0;
            lit_next = 1;
            halted = 0;
            o_fails = 0;
            chunk_q.delete();
        end else begin
            if (i_cfg_we) width = clamp_bits(i_cfg_data);
            if (i_valid && !i_in_stall) decode_byte(i_compressed_byte);
            if (i_out_valid && !i_out_stall) begin
                if (chunk_q.size() == 0) begin
                    $error("output transaction with nothing expected");
                    o_fails = o_fails + 1;
                end else begin
                    e = chunk_q.pop_front();
                    if (i_out_bytes !== e.bytes) begin
                        $error("out_bytes: expected %h, actual %h", e.bytes, i_out_bytes);
                        o_fails = o_fails + 1;
                    end
                    if (i_byte_count !== e.cnt) begin
                        $error("byte_count: expected %0d, actual %0d", e.cnt, i_byte_count);
                        o_fails = o_fails + 1;
                    end
                    if (i_last_of_run !== e.last) begin
                        $error("last_of_run: expected %0d, actual %0d", e.last,
                               i_last_of_run);
                        o_fails = o_fails + 1;
                    end
                    if (i_status !== e.st) begin
                        $error("status: expected %0d, actual %0d", e.st, i_status);
                        o_fails = o_fails + 1;
                    end
                end
            end
        end
        o_pending <= chunk_q.size();
    end

endmodule

@@ test/lzw_variable_width_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// lzw_variable_width_decoder_tb
// Builds legal LZW code streams at the decoder's current code width, packs
// them MSB first into bytes and feeds them with random idle and stall bursts.
// Covers literals, chain expansion, KwKwK codes, reset codes, width settings
// and a stop by end code.
// ----------------------------------------------------------------------------
module lzw_variable_width_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DICT    = 16384;
    localparam int MAXB    = 14;
    localparam int LONGEST = 512;
    localparam int LIMIT   = 3000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [3:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_compressed_byte = '0;
    logic        i_stall = 1'b0;
    logic        o_stall, o_valid, o_last_of_run;
    logic [63:0] o_out_bytes;
    logic [3:0]  o_byte_count;
    logic [1:0]  o_status;
    int          fails, pending;

    int              gw, gnext, gprev, pad_bits, accn;
    longint unsigned acc;
    bit              glit, ghalt, quiet;
    int              sent_bytes, codes_done, cfg_writes, cycles;
    int              hold_reqs, hold_done, hold_left, burst;
    int              chain_len[DICT];
    logic [3:0]      cfgs[6] = '{4'd0, 4'd12, 4'd15, 4'd10, 4'd6, 4'd9};

    always #6 i_clk = ~i_clk;

    lzw_variable_width_decoder u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall), .i_compressed_byte(i_compressed_byte),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_out_bytes(o_out_bytes), .o_byte_count(o_byte_count),
        .o_last_of_run(o_last_of_run), .o_status(o_status)
    );

    lzw_variable_width_decoder_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .i_in_stall(o_stall), .i_compressed_byte(i_compressed_byte),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_out_bytes(o_out_bytes), .i_byte_count(o_byte_count),
        .i_last_of_run(o_last_of_run), .i_status(o_status),
        .o_fails(fails), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("lzw_variable_width_decoder regression: fail");
            $finish;
        end
    end

    // receiver side: random stall bursts, one long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (hold_done != hold_reqs) begin
                hold_left = 400;
                hold_done = hold_reqs;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (quiet) begin
                i_stall <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                i_stall <= 1'b1;
            end else if ($urandom_range(9) == 0) begin
                burst = $urandom_range(6, 1) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    function automatic int lenof(input int c);
        return (c < 256) ? 1 : chain_len[c];
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (!quiet && $urandom_range(7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_compressed_byte <= b;
        do @(posedge i_clk); while (o_stall);
        sent_bytes++;
    endtask

    task automatic push_code(input int c);
        int bits;
        bits = gw - pad_bits;
        pad_bits = 0;
        acc = (acc << bits) | longint'(c & ((1 << bits) - 1));
        accn += bits;
        while (accn >= 8) begin
            send_byte(8'(acc >> (accn - 8)));
            accn -= 8;
            acc &= (64'd1 << accn) - 1;
        end
    endtask

    task automatic flush_bits();
        int p;
        if (accn > 0) begin
            p = 8 - accn;
            send_byte(8'(acc << p));
            acc = 0;
            accn = 0;
            pad_bits = p;
        end
    endtask

    // tracks the decoder's dictionary state one code ahead
    task automatic do_code(input int c);
        int msk, l;
        msk = (1 << gw) - 1;
        push_code(c);
        codes_done++;
        if (glit) begin
            glit = 0;
            gprev = c;
        end else if (c == msk) begin
            ghalt = 1;
        end else if (c == msk - 1) begin
            gnext = 256;
            glit = 1;
        end else begin
            l = (c >= gnext) ? lenof(gprev) + 1 : lenof(c);
            if (l > LONGEST) begin
                ghalt = 1;
            end else begin
                if (gnext < DICT) begin
                    chain_len[gnext] = lenof(gprev) + 1;
                    gnext++;
                end
                if (gnext > msk - 3 && gw < MAXB) gw++;
                gprev = c;
            end
        end
    endtask

    task automatic lit();
        int lim;
        lim = (1 << (gw - pad_bits)) - 1;
        if (lim > 255) lim = 255;
        do_code($urandom_range(lim));
    endtask

    task automatic rand_code();
        int msk, r, c;
        if (glit) begin
            lit();
            return;
        end
        msk = (1 << gw) - 1;
        r = $urandom_range(99);
        if (r < 6) begin
            c = msk - 1;
        end else if (r < 22 && gnext < DICT && gnext < msk - 1 && lenof(gprev) < LONGEST) begin
            c = gnext;
        end else if (r < 50) begin
            c = $urandom_range(255);
        end else begin
            c = $urandom_range(gnext - 1);
            if (c >= msk - 1 || lenof(c) > LONGEST) c = $urandom_range(255);
        end
        do_code(c);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic end_phase();
        if (!glit && !ghalt) do_code((1 << gw) - 2);
        flush_bits();
    endtask

    task automatic start_phase(input logic [3:0] v);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_writes++;
        gw = (v < lzwd_pkg::MIN_CODE_BITS) ? lzwd_pkg::MIN_CODE_BITS : (v > MAXB) ? MAXB : v;
    endtask

    initial begin
        gw = lzwd_pkg::MIN_CODE_BITS;
        gnext = 256;
        glit = 1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: literal extremes, chain, KwKwK, reset code
        start_phase(4'd9);
        do_code(0);
        do_code(255);
        do_code(256);
        do_code(gnext);
        do_code(gnext);
        do_code(0);
        do_code(258);
        do_code((1 << gw) - 2);
        do_code(255);
        do_code(gnext);
        do_code(gnext - 1);
        do_code(gnext);
        end_phase();

        for (int ph = 0; ph < 7; ph++) begin
            start_phase(ph < 6 ? cfgs[ph] : 4'($urandom_range(15)));
            if (ph == 2) hold_reqs++;
            repeat (20) rand_code();
            end_phase();
        end

        quiet = 1;
        start_phase(4'd14);
        repeat (20) rand_code();
        if (glit) lit();
        do_code((1 << gw) - 1);
        flush_bits();
        repeat (4) send_byte(8'($urandom_range(255)));
        settle();
        repeat (40) @(posedge i_clk);

        $display("sent %0d bytes carrying %0d codes over %0d register settings",
                 sent_bytes, codes_done, cfg_writes);
        $display("one long output hold, stream stopped by end code, later bytes ignored");
        if (fails == 0) begin
            $display("lzw_variable_width_decoder regression: pass");
        end else begin
            $display("lzw_variable_width_decoder regression: fail");
        end
        $finish;
    end

endmodule
